@@ sv/unsigned_radix_to_ascii_core_defines.svh @@
// Assertion macros shared by the conversion core.
`ifndef UNSIGNED_RADIX_TO_ASCII_CORE_DEFINES_SVH
`define UNSIGNED_RADIX_TO_ASCII_CORE_DEFINES_SVH

`ifndef SYNTHESIS
`define URTA_ASSERT_CLK(lbl, clk, rst_n, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
`define URTA_ASSERT(lbl, prop, msg) `URTA_ASSERT_CLK(lbl, clk_i, rst_ni, prop, msg)
`else
`define URTA_ASSERT_CLK(lbl, clk, rst_n, prop, msg)
`define URTA_ASSERT(lbl, prop, msg)
`endif

`endif

@@ sv/urta_pkg.sv @@
package urta_pkg;

  localparam int unsigned ValueWidthDef = 64;
  localparam int unsigned DataW         = 64;
  localparam int unsigned CharW         = 7;
  localparam int unsigned CountW        = 7;
  localparam int unsigned RadixW        = 5;
  localparam int unsigned DigitW        = 4;
  localparam int unsigned OutDataW      = 16;
  localparam int unsigned StepBits      = 8;
  localparam int unsigned QueueDepth    = 2;

  localparam logic [RadixW-1:0] RadixDef = 5'd10;
  localparam logic [RadixW-1:0] RadixMin = 5'd2;
  localparam logic [RadixW-1:0] RadixMax = 5'd16;

  localparam logic [CharW-1:0] ChZero = 7'h30;
  localparam logic [CharW-1:0] ChA    = 7'h41;

  // one finished number waiting in the digit store
  typedef struct packed {
    logic              bank;
    logic [CountW-1:0] cnt;
  } desc_t;

  function automatic logic [CharW-1:0] digit_to_ascii(logic [DigitW-1:0] d);
    logic [CharW-1:0] c;
    if (d < 4'd10) begin
      c = ChZero + CharW'(d);
    end else begin
      c = ChA + CharW'(d - 4'd10);
    end
    return c;
  endfunction

endpackage

@@ sv/urta_ram.sv @@
module urta_ram #(
  parameter int unsigned WIDTH = 4,
  parameter int unsigned DEPTH = 128
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // hold read data while no read is requested
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

@@ sv/urta_fifo.sv @@
module urta_fifo (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            push_i,
  input  urta_pkg::desc_t push_data_i,
  input  logic            pop_i,
  output urta_pkg::desc_t head_o,
  output logic            valid_o,
  output logic            full_o
);
  import urta_pkg::*;

  localparam int unsigned PtrW = (QueueDepth > 1) ? $clog2(QueueDepth) : 1;
  localparam int unsigned CntW = $clog2(QueueDepth + 1);

  desc_t           entry_q [QueueDepth];
  logic [PtrW-1:0] wptr_q, wptr_d;
  logic [PtrW-1:0] rptr_q, rptr_d;
  logic [CntW-1:0] cnt_q, cnt_d;

  always_comb begin
    wptr_d = wptr_q;
    rptr_d = rptr_q;
    cnt_d  = cnt_q;
    if (push_i) begin
      wptr_d = (wptr_q == PtrW'(QueueDepth - 1)) ? '0 : wptr_q + 1'b1;
    end
    if (pop_i) begin
      rptr_d = (rptr_q == PtrW'(QueueDepth - 1)) ? '0 : rptr_q + 1'b1;
    end
    if (push_i && !pop_i) begin
      cnt_d = cnt_q + 1'b1;
    end else if (pop_i && !push_i) begin
      cnt_d = cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q <= '0;
      rptr_q <= '0;
      cnt_q  <= '0;
    end else begin
      wptr_q <= wptr_d;
      rptr_q <= rptr_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      entry_q[wptr_q] <= push_data_i;
    end
  end

  assign head_o  = entry_q[rptr_q];
  assign valid_o = (cnt_q != '0);
  assign full_o  = (cnt_q == CntW'(QueueDepth));

endmodule

@@ sv/urta_front.sv @@
module urta_front #(
  parameter int unsigned VALUE_WIDTH = 64
) (
  input  logic                                  clk_i,
  input  logic                                  rst_ni,
  input  logic                                  in_valid_i,
  output logic                                  in_ready_o,
  input  logic [urta_pkg::DataW-1:0]            in_value_i,
  input  logic [urta_pkg::RadixW-1:0]           radix_i,
  output logic                                  ram_we_o,
  output logic [$clog2(VALUE_WIDTH):0]          ram_waddr_o,
  output logic [urta_pkg::DigitW-1:0]           ram_wdata_o,
  output logic                                  push_o,
  output urta_pkg::desc_t                       push_data_o,
  input  logic                                  queue_full_i
);
  import urta_pkg::*;

  localparam int unsigned IdxW     = $clog2(VALUE_WIDTH);
  localparam int unsigned Steps    = (VALUE_WIDTH + StepBits - 1) / StepBits;
  localparam int unsigned PadW     = Steps * StepBits;
  localparam int unsigned StepCntW = (Steps > 1) ? $clog2(Steps) : 1;

  typedef enum logic [1:0] {
    FsIdle = 2'b01,
    FsDiv  = 2'b10
  } front_state_e;

  front_state_e          state_q, state_d;
  logic [PadW-1:0]       work_q, work_d;
  logic [DigitW-1:0]     rem_q, rem_d;
  logic [StepCntW-1:0]   step_q, step_d;
  logic [CountW-1:0]     ndig_q, ndig_d;
  logic [RadixW-1:0]     base_q, base_d;
  logic                  bank_q, bank_d;

  logic [PadW-1:0]       work_next;
  logic [DigitW-1:0]     rem_next;
  logic                  digit_done;
  logic                  accept;

  // eight restoring division steps per cycle on the narrow remainder
  always_comb begin
    logic [RadixW-1:0]   part;
    logic [DigitW-1:0]   r;
    logic [StepBits-1:0] qb;
    r  = rem_q;
    qb = '0;
    for (int i = 0; i < StepBits; i++) begin
      part = {r, work_q[PadW-1-i]};
      if (part >= base_q) begin
        part = part - base_q;
        qb[StepBits-1-i] = 1'b1;
      end
      r = part[DigitW-1:0];
    end
    rem_next  = r;
    work_next = (work_q << StepBits) | PadW'(qb);
  end

  assign accept     = in_valid_i && in_ready_o;
  assign in_ready_o = (state_q == FsIdle) && !queue_full_i;
  assign digit_done = (state_q == FsDiv) && (step_q == StepCntW'(Steps - 1));

  always_comb begin
    state_d = state_q;
    work_d  = work_q;
    rem_d   = rem_q;
    step_d  = step_q;
    ndig_d  = ndig_q;
    base_d  = base_q;
    bank_d  = bank_q;
    unique case (state_q)
      FsIdle: begin
        if (accept) begin
          work_d  = PadW'(in_value_i[VALUE_WIDTH-1:0]);
          rem_d   = '0;
          step_d  = '0;
          ndig_d  = '0;
          base_d  = (radix_i < RadixMin || radix_i > RadixMax) ? RadixDef : radix_i;
          state_d = FsDiv;
        end
      end
      FsDiv: begin
        if (digit_done) begin
          ndig_d = ndig_q + 1'b1;
          rem_d  = '0;
          step_d = '0;
          work_d = work_next;
          // quotient exhausted: hand the number to the back end
          if (work_next == '0) begin
            bank_d  = !bank_q;
            state_d = FsIdle;
          end
        end else begin
          rem_d  = rem_next;
          step_d = step_q + 1'b1;
          work_d = work_next;
        end
      end
      default: state_d = FsIdle;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= FsIdle;
      step_q  <= '0;
      ndig_q  <= '0;
      bank_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      step_q  <= step_d;
      ndig_q  <= ndig_d;
      bank_q  <= bank_d;
    end
  end

  always_ff @(posedge clk_i) begin
    work_q <= work_d;
    rem_q  <= rem_d;
    base_q <= base_d;
  end

  assign ram_we_o         = digit_done;
  assign ram_waddr_o      = {bank_q, ndig_q[IdxW-1:0]};
  assign ram_wdata_o      = rem_next;
  assign push_o           = digit_done && (work_next == '0);
  assign push_data_o.bank = bank_q;
  assign push_data_o.cnt  = ndig_q + 1'b1;

endmodule

@@ sv/urta_back.sv @@
module urta_back #(
  parameter int unsigned VALUE_WIDTH = 64
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  urta_pkg::desc_t                head_i,
  input  logic                           head_valid_i,
  output logic                           pop_o,
  output logic                           ram_re_o,
  output logic [$clog2(VALUE_WIDTH):0]   ram_raddr_o,
  input  logic [urta_pkg::DigitW-1:0]    ram_rdata_i,
  output logic                           out_valid_o,
  input  logic                           out_ready_i,
  output logic [urta_pkg::OutDataW-1:0]  out_data_o,
  output logic                           out_last_o
);
  import urta_pkg::*;

  localparam int unsigned IdxW = $clog2(VALUE_WIDTH);

  logic [CountW-1:0] sent_q, sent_d;
  logic              out_valid_q, out_valid_d;
  logic              out_last_q;
  logic [CountW-1:0] out_cnt_q;

  logic              issue;
  logic              is_last;
  logic [CountW-1:0] idx;

  // read most significant digit first; the RAM output register is the output stage
  assign issue   = head_valid_i && (!out_valid_q || out_ready_i);
  assign is_last = (sent_q + 1'b1 == head_i.cnt);
  assign idx     = head_i.cnt - 1'b1 - sent_q;

  always_comb begin
    sent_d      = sent_q;
    out_valid_d = out_valid_q;
    if (issue) begin
      sent_d      = is_last ? '0 : sent_q + 1'b1;
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sent_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      sent_q      <= sent_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (issue) begin
      out_last_q <= is_last;
      out_cnt_q  <= is_last ? head_i.cnt : '0;
    end
  end

  assign pop_o       = issue && is_last;
  assign ram_re_o    = issue;
  assign ram_raddr_o = {head_i.bank, idx[IdxW-1:0]};
  assign out_valid_o = out_valid_q;
  assign out_last_o  = out_last_q;
  assign out_data_o  = {(OutDataW - CharW - CountW)'(0), out_cnt_q,
                        digit_to_ascii(ram_rdata_i)};

endmodule

@@ sv/unsigned_radix_to_ascii_core.sv @@
// The divider writes each number's digits least significant first into one bank of the digit store;
// the back end then reads them most significant first, and digits leave one per cycle while the
// receiver is ready. The 8-bit-per-cycle divider works digit by digit on the value; the front takes
// a new value while one earlier number is emitted.
// Reset: asynchronous, active low; clears control state and sets radix to ten.
// The digit store is not cleared, every entry is written before it is read.
`include "unsigned_radix_to_ascii_core_defines.svh"

module unsigned_radix_to_ascii_core #(
  parameter int unsigned VALUE_WIDTH = urta_pkg::ValueWidthDef
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_we_i,
  input  logic [urta_pkg::RadixW-1:0]   cfg_wdata_i,
  input  logic                          s_axis_tvalid_i,
  output logic                          s_axis_tready_o,
  input  logic [urta_pkg::DataW-1:0]    s_axis_tdata_i,  // [63:0] value
  output logic                          m_axis_tvalid_o,
  input  logic                          m_axis_tready_i,
  output logic [urta_pkg::OutDataW-1:0] m_axis_tdata_o,  // [6:0] digit_char, [13:7] digit_count
  output logic                          m_axis_tlast_o
);
  import urta_pkg::*;

  localparam int unsigned AddrW = $clog2(VALUE_WIDTH) + 1;

  logic [RadixW-1:0] radix_q;

  logic              ram_we;
  logic [AddrW-1:0]  ram_waddr;
  logic [DigitW-1:0] ram_wdata;
  logic              ram_re;
  logic [AddrW-1:0]  ram_raddr;
  logic [DigitW-1:0] ram_rdata;

  logic              push;
  desc_t             push_data;
  logic              pop;
  desc_t             head;
  logic              head_valid;
  logic              queue_full;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      radix_q <= RadixDef;
    end else if (cfg_we_i) begin
      radix_q <= cfg_wdata_i;
    end
  end

  urta_front #(
    .VALUE_WIDTH(VALUE_WIDTH)
  ) u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (s_axis_tvalid_i),
    .in_ready_o  (s_axis_tready_o),
    .in_value_i  (s_axis_tdata_i),
    .radix_i     (radix_q),
    .ram_we_o    (ram_we),
    .ram_waddr_o (ram_waddr),
    .ram_wdata_o (ram_wdata),
    .push_o      (push),
    .push_data_o (push_data),
    .queue_full_i(queue_full)
  );

  // two banks: one being filled, one being emitted
  urta_ram #(
    .WIDTH(DigitW),
    .DEPTH(2 ** AddrW)
  ) u_ram (
    .clk_i  (clk_i),
    .we_i   (ram_we),
    .waddr_i(ram_waddr),
    .wdata_i(ram_wdata),
    .re_i   (ram_re),
    .raddr_i(ram_raddr),
    .rdata_o(ram_rdata)
  );

  urta_fifo u_fifo (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .push_i     (push),
    .push_data_i(push_data),
    .pop_i      (pop),
    .head_o     (head),
    .valid_o    (head_valid),
    .full_o     (queue_full)
  );

  urta_back #(
    .VALUE_WIDTH(VALUE_WIDTH)
  ) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .head_i      (head),
    .head_valid_i(head_valid),
    .pop_o       (pop),
    .ram_re_o    (ram_re),
    .ram_raddr_o (ram_raddr),
    .ram_rdata_i (ram_rdata),
    .out_valid_o (m_axis_tvalid_o),
    .out_ready_i (m_axis_tready_i),
    .out_data_o  (m_axis_tdata_o),
    .out_last_o  (m_axis_tlast_o)
  );

  `URTA_ASSERT(a_busy_after_accept, s_axis_tvalid_i && s_axis_tready_o |=> !s_axis_tready_o, "front took a request while dividing")
  `URTA_ASSERT(a_push_not_full, push |-> !queue_full, "descriptor pushed into a full queue")
  `URTA_ASSERT(a_pop_has_head, pop |-> head_valid, "descriptor popped from an empty queue")
  `URTA_ASSERT(a_count_on_last, m_axis_tvalid_o |-> ((m_axis_tdata_o[13:7] != 7'd0) == m_axis_tlast_o), "digit count does not match last flag")
  `URTA_ASSERT(a_count_bound, push |-> (push_data.cnt != 7'd0) && (push_data.cnt <= CountW'(VALUE_WIDTH)), "digit count out of range")

endmodule

@@ verif/unsigned_radix_to_ascii_checker.sv @@
`timescale 1ns / 100ps

module unsigned_radix_to_ascii_checker #(
  parameter int unsigned VALUE_WIDTH = urta_pkg::ValueWidthDef
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_we_i,
  input  logic [urta_pkg::RadixW-1:0]   cfg_wdata_i,
  input  logic                          s_tvalid_i,
  input  logic                          s_tready_i,
  input  logic [urta_pkg::DataW-1:0]    s_tdata_i,   // [63:0] value
  input  logic                          m_tvalid_i,
  input  logic                          m_tready_i,
  input  logic [urta_pkg::OutDataW-1:0] m_tdata_i,   // [6:0] digit_char, [13:7] digit_count
  input  logic                          m_tlast_i,
  output int                            errors_o,
  output int                            pending_o,
  output int                            values_o,
  output int                            digits_o
);
  import urta_pkg::*;

  typedef struct packed {
    logic [CharW-1:0]  ch;
    logic [CountW-1:0] cnt;
    logic              last;
  } digit_t;

  digit_t              digits_due[$];
  logic [RadixW-1:0]   radix_q = RadixDef;
  int                  err_cnt = 0;
  int                  value_cnt = 0;
  int                  digit_cnt = 0;

  assign errors_o  = err_cnt;
  assign pending_o = digits_due.size();
  assign values_o  = value_cnt;
  assign digits_o  = digit_cnt;

  // Expand one number into its digit requests, most significant first.
  task automatic queue_digits(input logic [DataW-1:0] value);
    logic [DataW-1:0]  quot;
    logic [DataW-1:0]  base;
    logic [DigitW-1:0] rems[64];
    int                n;
    digit_t            d;
    base = (radix_q < RadixMin || radix_q > RadixMax) ? DataW'(RadixDef) : DataW'(radix_q);
    quot = (VALUE_WIDTH >= DataW) ? value : (value & ((DataW'(1) << VALUE_WIDTH) - 1));
    n = 0;
    if (quot == '0) begin
      rems[0] = '0;
      n = 1;
    end else begin
      while (quot != '0 && n < 64) begin
        rems[n] = DigitW'(quot % base);
        quot = quot / base;
        n++;
      end
    end
    for (int k = n - 1; k >= 0; k--) begin
      d.ch   = (rems[k] < 4'd10) ? ChZero + CharW'(rems[k]) : ChA + CharW'(rems[k] - 4'd10);
      d.last = (k == 0);
      d.cnt  = d.last ? CountW'(n) : '0;
      digits_due.push_back(d);
    end
    value_cnt++;
  endtask

  task automatic flag_mismatch(input string why, input digit_t exp_d, input digit_t got_d);
    err_cnt++;
    if (err_cnt <= 10) begin
      $display("%0t: %s: expected char %h count %0d last %b, got char %h count %0d last %b",
               $time, why, exp_d.ch, exp_d.cnt, exp_d.last, got_d.ch, got_d.cnt, got_d.last);
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    digit_t got_d;
    digit_t exp_d;
    if (!rst_ni) begin
      radix_q = RadixDef;
      digits_due.delete();
    end else begin
      if (cfg_we_i) begin
        radix_q = cfg_wdata_i;
      end
      if (s_tvalid_i && s_tready_i) begin
        queue_digits(s_tdata_i);
      end
      if (m_tvalid_i && m_tready_i) begin
        got_d.ch   = m_tdata_i[6:0];
        got_d.cnt  = m_tdata_i[13:7];
        got_d.last = m_tlast_i;
        digit_cnt++;
        if (digits_due.size() == 0) begin
          exp_d = '0;
          flag_mismatch("digit with no request pending", exp_d, got_d);
        end else begin
          exp_d = digits_due.pop_front();
          if (got_d !== exp_d) begin
            flag_mismatch("digit mismatch", exp_d, got_d);
          end
        end
      end
    end
  end

endmodule

@@ verif/tb_unsigned_radix_to_ascii_core.sv @@
`timescale 1ns / 100ps

module tb_unsigned_radix_to_ascii_core;
  import urta_pkg::*;

  localparam int TimeoutCycles = 1000000;
  localparam int HoldCycles    = 400;
  localparam int PhaseValues   = 16;

  logic                  clk_i = 1'b0;
  logic                  rst_ni = 1'b0;
  logic                  cfg_we = 1'b0;
  logic [RadixW-1:0]     cfg_wdata = '0;
  logic                  s_tvalid = 1'b0;
  logic                  s_tready;
  logic [DataW-1:0]      s_tdata = '0;
  logic                  m_tvalid;
  logic                  m_tready = 1'b0;
  logic [OutDataW-1:0]   m_tdata;
  logic                  m_tlast;

  logic                  hold_req = 1'b0;
  logic                  hold_ack = 1'b0;

  int                    mismatches;
  int                    digits_pending;
  int                    values_seen;
  int                    digits_seen;
  int                    radix_writes = 0;
  logic [DataW-1:0]      value_q[$];

  always #4 clk_i = ~clk_i;

  unsigned_radix_to_ascii_core uut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cfg_we_i        (cfg_we),
    .cfg_wdata_i     (cfg_wdata),
    .s_axis_tvalid_i (s_tvalid),
    .s_axis_tready_o (s_tready),
    .s_axis_tdata_i  (s_tdata),
    .m_axis_tvalid_o (m_tvalid),
    .m_axis_tready_i (m_tready),
    .m_axis_tdata_o  (m_tdata),
    .m_axis_tlast_o  (m_tlast)
  );

  unsigned_radix_to_ascii_checker checker_i (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we),
    .cfg_wdata_i (cfg_wdata),
    .s_tvalid_i  (s_tvalid),
    .s_tready_i  (s_tready),
    .s_tdata_i   (s_tdata),
    .m_tvalid_i  (m_tvalid),
    .m_tready_i  (m_tready),
    .m_tdata_i   (m_tdata),
    .m_tlast_i   (m_tlast),
    .errors_o    (mismatches),
    .pending_o   (digits_pending),
    .values_o    (values_seen),
    .digits_o    (digits_seen)
  );

  // Receiver: stretches of always-ready, random, sparse and mostly-ready acceptance, plus one long hold.
  initial begin : digit_sink
    int mode;
    int span;
    forever begin
      mode = $urandom_range(0, 3);
      span = $urandom_range(20, 200);
      repeat (span) begin
        @(negedge clk_i);
        if (hold_req && !hold_ack) begin
          m_tready <= 1'b0;
          repeat (HoldCycles - 1) @(negedge clk_i);
          hold_ack <= 1'b1;
        end else begin
          case (mode)
            0:       m_tready <= 1'b1;
            1:       m_tready <= 1'($urandom_range(0, 1));
            2:       m_tready <= ($urandom_range(0, 7) == 0);
            default: m_tready <= ($urandom_range(0, 3) != 0);
          endcase
        end
      end
    end
  end

  initial begin : watchdog
    repeat (TimeoutCycles) @(posedge clk_i);
    $display("timeout with %0d digits still pending", digits_pending);
    $display("[unsigned_radix_to_ascii_core] ERROR");
    $finish;
  end

  task automatic send_value(input logic [DataW-1:0] value);
    @(negedge clk_i);
    s_tvalid <= 1'b1;
    s_tdata  <= value;
    do @(posedge clk_i); while (!s_tready);
  endtask

  // Drain the value queue in bursts; gaps are skipped when back_to_back is set.
  task automatic send_queued(input bit back_to_back);
    int burst;
    int gap;
    burst = $urandom_range(1, 12);
    while (value_q.size() != 0) begin
      send_value(value_q.pop_front());
      burst--;
      if (burst == 0 && !back_to_back) begin
        burst = $urandom_range(1, 12);
        gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 60);
        if (gap > 0) begin
          @(negedge clk_i);
          s_tvalid <= 1'b0;
          repeat (gap - 1) @(negedge clk_i);
        end
      end
    end
    @(negedge clk_i);
    s_tvalid <= 1'b0;
  endtask

  task automatic wait_drained();
    do @(negedge clk_i); while (digits_pending != 0);
    repeat (4) @(negedge clk_i);
  endtask

  task automatic set_radix(input logic [RadixW-1:0] radix);
    wait_drained();
    @(negedge clk_i);
    cfg_we    <= 1'b1;
    cfg_wdata <= radix;
    @(negedge clk_i);
    cfg_we    <= 1'b0;
    radix_writes++;
  endtask

  function automatic logic [DataW-1:0] pick_value(input logic [RadixW-1:0] radix);
    logic [DataW-1:0] base;
    logic [DataW-1:0] pow;
    logic [DataW-1:0] v;
    int               k;
    base = (radix < RadixMin || radix > RadixMax) ? DataW'(RadixDef) : DataW'(radix);
    case ($urandom_range(0, 5))
      0: v = {$urandom, $urandom};
      1: v = DataW'($urandom_range(0, 300));
      2: v = {$urandom, $urandom} >> $urandom_range(0, 63);
      3: v = $urandom_range(0, 1) ? '1 : (DataW'(1) << $urandom_range(0, 63));
      default: begin
        // land on a digit-count boundary of the current base
        k = $urandom_range(1, 64);
        pow = 1;
        repeat (k) begin
          if (pow <= '1 / base) pow = pow * base;
        end
        v = pow - DataW'($urandom_range(0, 1));
      end
    endcase
    return v;
  endfunction

  initial begin : stimulus
    logic [RadixW-1:0] phase_radix[8];
    phase_radix = '{5'd2, 5'd16, 5'd31, 5'd10, 5'd1, 5'd0, 5'd17, 5'd0};
    phase_radix[7] = RadixW'($urandom_range(0, 31));

    repeat (3) @(negedge clk_i);
    rst_ni <= 1'b1;

    // reset radix is ten
    value_q = '{64'd0, 64'd1, 64'd9, 64'd10, '1, 64'h8AC7_2304_89E8_0000,
                64'h8000_0000_0000_0000};
    send_queued(1'b0);
    set_radix(5'd2);
    value_q = '{64'd0, 64'd1, '1, 64'h8000_0000_0000_0000, 64'h5555_5555_5555_5555};
    send_queued(1'b0);
    set_radix(5'd16);
    value_q = '{'1, 64'h0123_4567_89AB_CDEF, 64'hFEDC_BA98_7654_3210, 64'd15};
    send_queued(1'b0);
    // out-of-range bases fall back to ten
    set_radix(5'd0);
    value_q = '{64'd12345};
    send_queued(1'b0);
    set_radix(5'd1);
    value_q = '{'1};
    send_queued(1'b0);
    set_radix(5'd17);
    value_q = '{64'd100};
    send_queued(1'b0);
    set_radix(5'd31);
    value_q = '{64'd0};
    send_queued(1'b0);
    set_radix(5'd3);
    value_q = '{'1};
    send_queued(1'b0);
    set_radix(5'd7);
    value_q = '{64'd48};
    send_queued(1'b0);

    for (int p = 0; p < 8; p++) begin
      set_radix(phase_radix[p]);
      if (p == 1) begin
        // fill the block while the sink holds off
        @(negedge clk_i);
        hold_req <= 1'b1;
        repeat (8) value_q.push_back(DataW'($urandom_range(1, 255)));
        send_queued(1'b1);
        wait (hold_ack);
      end
      repeat (PhaseValues) value_q.push_back(pick_value(phase_radix[p]));
      send_queued(1'b0);
    end

    wait_drained();
    repeat (100) @(negedge clk_i);

    $display("converted %0d values into %0d digits across %0d radix writes",
             values_seen, digits_seen, radix_writes);
    $display("bases 2, 16 and out-of-range covered, one long sink hold included");
    if (mismatches == 0 && digits_pending == 0) begin
      $display("[unsigned_radix_to_ascii_core] OK");
    end else begin
      $display("[unsigned_radix_to_ascii_core] ERROR");
    end
    $finish;
  end

endmodule
